// ----- rtl/mtif_pkg.sv -----
// Shared types, track byte constants and CRC helper for the MFM track formatter.
package mtif_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_HEADER = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;

  localparam logic [7:0] B_GAP          = 8'h4E;
  localparam logic [7:0] B_ZERO         = 8'h00;
  localparam logic [7:0] B_SYNC_A1      = 8'hA1;
  localparam logic [7:0] B_ID_MARK      = 8'hFE;
  localparam logic [7:0] B_DATA_MARK    = 8'hFB;
  localparam logic [7:0] B_DELETED_MARK = 8'hF8;
  localparam logic [7:0] B_INDEX_SYNC   = 8'hC2;
  localparam logic [7:0] B_INDEX_MARK   = 8'hFC;

  localparam logic [7:0] ST_ID_CRC_ERR   = 8'hA0;
  localparam logic [7:0] ST_DATA_CRC_ERR = 8'hB0;
  localparam logic [7:0] ST_NO_ID        = 8'hE0;
  localparam logic [7:0] ST_NO_DATA      = 8'hF0;

  localparam logic [6:0] LEN_ONE   = 7'd1;
  localparam logic [6:0] LEN_MARKS = 7'd3;
  localparam logic [6:0] LEN_SYNC  = 7'd12;
  localparam logic [6:0] LEN_GAP4A = 7'd80;
  localparam logic [6:0] LEN_GAP1  = 7'd50;
  localparam logic [6:0] LEN_GAP2  = 7'd22;
  localparam logic [6:0] LEN_GAP3  = 7'd84;

  localparam logic [10:0] SECTOR_BYTES = 11'd128;

  typedef logic [3:0] beat_idx_t;

  // start track beats
  localparam beat_idx_t SB_GAP4A    = 4'd0;
  localparam beat_idx_t SB_SYNC     = 4'd1;
  localparam beat_idx_t SB_IAM_SYNC = 4'd2;
  localparam beat_idx_t SB_IAM      = 4'd3;
  localparam beat_idx_t SB_GAP1     = 4'd4;

  // sector header beats
  localparam beat_idx_t HB_SYNC   = 4'd0;
  localparam beat_idx_t HB_A1     = 4'd1;
  localparam beat_idx_t HB_FE     = 4'd2;
  localparam beat_idx_t HB_C      = 4'd3;
  localparam beat_idx_t HB_H      = 4'd4;
  localparam beat_idx_t HB_R      = 4'd5;
  localparam beat_idx_t HB_N      = 4'd6;
  localparam beat_idx_t HB_CRC_HI = 4'd7;
  localparam beat_idx_t HB_CRC_LO = 4'd8;
  localparam beat_idx_t HB_GAP2   = 4'd9;
  localparam beat_idx_t HB_DSYNC  = 4'd10;
  localparam beat_idx_t HB_DA1    = 4'd11;
  localparam beat_idx_t HB_DMARK  = 4'd12;

  // data byte beats
  localparam beat_idx_t DB_BYTE   = 4'd0;
  localparam beat_idx_t DB_CRC_HI = 4'd1;
  localparam beat_idx_t DB_CRC_LO = 4'd2;
  localparam beat_idx_t DB_GAP3   = 4'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  cylinder;
    logic [7:0]  head_id;
    logic [7:0]  record_id;
    logic [7:0]  size_code;
    logic [7:0]  mark;
    logic [7:0]  data_byte;
    logic [15:0] crc;
    logic        crc_inv;
    beat_idx_t   last_idx;
  } item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic [6:0] run_length;
    logic       id_mark;
    logic       last;
  } result_t;

  // CRC-16-CCITT, one byte, MSB first
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_SYNC3 =
    crc_update(crc_update(crc_update(CRC_INIT, B_SYNC_A1), B_SYNC_A1), B_SYNC_A1);
  localparam logic [15:0] CRC_ID_SEED      = crc_update(CRC_SYNC3, B_ID_MARK);
  localparam logic [15:0] CRC_DATA_SEED    = crc_update(CRC_SYNC3, B_DATA_MARK);
  localparam logic [15:0] CRC_DELETED_SEED = crc_update(CRC_SYNC3, B_DELETED_MARK);

endpackage

// ----- rtl/mtif_in_if.sv -----
// Input item channel of the MFM track formatter.
interface mtif_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] cylinder;
  logic [7:0] head_id;
  logic [7:0] record_id;
  logic [7:0] size_code;
  logic [7:0] sector_status;
  logic       deleted;
  logic [7:0] data_byte;

  modport source (
    output valid, operation, cylinder, head_id, record_id, size_code,
           sector_status, deleted, data_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, cylinder, head_id, record_id, size_code,
           sector_status, deleted, data_byte,
    output ready
  );
endinterface

// ----- rtl/mtif_out_if.sv -----
// Output run channel of the MFM track formatter.
interface mtif_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [6:0] run_length;
  logic       id_mark;
  logic       last;

  modport source (
    output valid, byte_value, run_length, id_mark, last,
    input  ready
  );
  modport sink (
    input  valid, byte_value, run_length, id_mark, last,
    output ready
  );
endinterface

// ----- rtl/mtif_run_gen.sv -----
// Run record generator: picks the track run for one beat of the current item.
module mtif_run_gen (
  input  mtif_pkg::item_t     item,
  input  mtif_pkg::beat_idx_t idx,
  output mtif_pkg::result_t   res
);
  import mtif_pkg::*;

  logic [15:0] crc_out;

  assign crc_out = item.crc ^ {16{item.crc_inv}};

  always_comb begin
    res.byte_value = B_ZERO;
    res.run_length = LEN_ONE;
    res.id_mark    = 1'b0;
    res.last       = (idx == item.last_idx);
    case (item.kind)
      OP_START: begin
        case (idx)
          SB_GAP4A: begin
            res.byte_value = B_GAP;
            res.run_length = LEN_GAP4A;
          end
          SB_SYNC: begin
            res.byte_value = B_ZERO;
            res.run_length = LEN_SYNC;
          end
          SB_IAM_SYNC: begin
            res.byte_value = B_INDEX_SYNC;
            res.run_length = LEN_MARKS;
          end
          SB_IAM: res.byte_value = B_INDEX_MARK;
          SB_GAP1: begin
            res.byte_value = B_GAP;
            res.run_length = LEN_GAP1;
          end
          default: ;
        endcase
      end
      OP_HEADER: begin
        case (idx)
          HB_SYNC, HB_DSYNC: begin
            res.byte_value = B_ZERO;
            res.run_length = LEN_SYNC;
          end
          HB_A1, HB_DA1: begin
            res.byte_value = B_SYNC_A1;
            res.run_length = LEN_MARKS;
          end
          HB_FE: begin
            res.byte_value = B_ID_MARK;
            res.id_mark    = 1'b1;
          end
          HB_C:      res.byte_value = item.cylinder;
          HB_H:      res.byte_value = item.head_id;
          HB_R:      res.byte_value = item.record_id;
          HB_N:      res.byte_value = item.size_code;
          HB_CRC_HI: res.byte_value = crc_out[15:8];
          HB_CRC_LO: res.byte_value = crc_out[7:0];
          HB_GAP2: begin
            res.byte_value = B_GAP;
            res.run_length = LEN_GAP2;
          end
          HB_DMARK:  res.byte_value = item.mark;
          default: ;
        endcase
      end
      OP_DATA: begin
        case (idx)
          DB_BYTE:   res.byte_value = item.data_byte;
          DB_CRC_HI: res.byte_value = crc_out[15:8];
          DB_CRC_LO: res.byte_value = crc_out[7:0];
          DB_GAP3: begin
            res.byte_value = B_GAP;
            res.run_length = LEN_GAP3;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/mfm_track_image_formatter.sv -----
// MFM track formatter top level: item decode, run sequencer and output register.
// The first run of an accepted item is registered in the item register, then in the
// output register. Throughput: one run per cycle while the output does not stall:
// data byte 1, final data byte 4, start track 5, sector header 10 or 13 runs.
// The next item is taken in the cycle the current item's last run is issued.
// Reset (rst, synchronous): data CRC to FFFF, no data field open, outputs empty.
module mfm_track_image_formatter (
  input logic        clk,
  input logic        rst,
  mtif_in_if.sink    items,
  mtif_out_if.source runs
);
  import mtif_pkg::*;

  logic        busy;
  beat_idx_t   idx;
  item_t       item;
  item_t       item_new;
  result_t     gen;
  result_t     res;
  logic        res_valid;
  logic        adv;
  logic        accept;
  logic        has_results;

  logic [15:0] crc_acc;
  logic [15:0] crc_acc_next;
  logic [15:0] crc_byte;
  logic [10:0] bytes_remaining;
  logic [10:0] bytes_remaining_next;
  logic        data_active;
  logic        data_active_next;
  logic        invert_data_crc;
  logic        invert_data_crc_next;

  mtif_run_gen u_gen (
    .item (item),
    .idx  (idx),
    .res  (gen)
  );

  assign adv         = busy && (!res_valid || runs.ready);
  assign items.ready = !busy || (adv && gen.last);
  assign accept      = items.valid && items.ready;
  assign crc_byte    = crc_update(crc_acc, items.data_byte);

  always_comb begin
    has_results          = 1'b0;
    crc_acc_next         = crc_acc;
    bytes_remaining_next = bytes_remaining;
    data_active_next     = data_active;
    invert_data_crc_next = invert_data_crc;
    item_new.kind        = items.operation;
    item_new.cylinder    = items.cylinder;
    item_new.head_id     = items.head_id;
    item_new.record_id   = items.record_id;
    item_new.size_code   = items.size_code;
    item_new.mark        = items.deleted ? B_DELETED_MARK : B_DATA_MARK;
    item_new.data_byte   = items.data_byte;
    item_new.crc         = CRC_ID_SEED;
    item_new.crc_inv     = (items.sector_status == ST_ID_CRC_ERR);
    item_new.last_idx    = SB_GAP1;
    case (items.operation)
      OP_START: begin
        has_results          = 1'b1;
        data_active_next     = 1'b0;
        bytes_remaining_next = '0;
      end
      OP_HEADER: begin
        data_active_next     = 1'b0;
        bytes_remaining_next = '0;
        if (items.sector_status != ST_NO_ID) begin
          has_results = 1'b1;
          if (items.sector_status == ST_NO_DATA) begin
            item_new.last_idx = HB_GAP2;
          end else begin
            item_new.last_idx    = HB_DMARK;
            crc_acc_next         = items.deleted ? CRC_DELETED_SEED : CRC_DATA_SEED;
            bytes_remaining_next = SECTOR_BYTES << items.size_code[1:0];
            data_active_next     = 1'b1;
            invert_data_crc_next = (items.sector_status == ST_DATA_CRC_ERR);
          end
        end
      end
      OP_DATA: begin
        if (data_active) begin
          has_results      = 1'b1;
          crc_acc_next     = crc_byte;
          item_new.crc     = crc_byte;
          item_new.crc_inv = invert_data_crc;
          bytes_remaining_next = (bytes_remaining != '0) ?
                                 bytes_remaining - 11'd1 : '0;
          if (bytes_remaining <= 11'd1) begin
            item_new.last_idx = DB_GAP3;
            data_active_next  = 1'b0;
          end else begin
            item_new.last_idx = DB_BYTE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc         <= CRC_INIT;
      bytes_remaining <= '0;
      data_active     <= 1'b0;
      invert_data_crc <= 1'b0;
    end else if (accept) begin
      crc_acc         <= crc_acc_next;
      bytes_remaining <= bytes_remaining_next;
      data_active     <= data_active_next;
      invert_data_crc <= invert_data_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (accept) begin
      busy <= has_results;
      idx  <= '0;
    end else if (adv) begin
      if (gen.last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  // ID CRC runs over C H R N as they go out
  always_ff @(posedge clk) begin
    if (accept && has_results) begin
      item <= item_new;
    end else if (adv && item.kind == OP_HEADER && idx >= HB_C && idx <= HB_N) begin
      item.crc <= crc_update(item.crc, gen.byte_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (runs.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= gen;
    end
  end

  assign runs.valid      = res_valid;
  assign runs.byte_value = res.byte_value;
  assign runs.run_length = res.run_length;
  assign runs.id_mark    = res.id_mark;
  assign runs.last       = res.last;

`ifndef SYNTHESIS
  a_active_has_bytes: assert property (@(posedge clk) disable iff (rst)
    data_active |-> bytes_remaining != '0)
    else $error("data field open with no bytes left");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= item.last_idx)
    else $error("beat index past last run of item");

  a_id_mark_byte: assert property (@(posedge clk) disable iff (rst)
    runs.valid && runs.id_mark |-> runs.byte_value == B_ID_MARK)
    else $error("id mark flag on a byte other than FE");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    runs.valid |-> runs.run_length != '0)
    else $error("zero length run");

  a_take_on_last: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready && busy |-> gen.last)
    else $error("new item taken before last run of current item");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the MFM track formatter: run prediction, stimulus and checks.
`timescale 1ns / 100ps

module testbench;
  import mtif_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEM_BUDGET = 440;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] cyl;
    logic [7:0] head;
    logic [7:0] rec;
    logic [7:0] size;
    logic [7:0] status;
    logic       del;
    logic [7:0] dbyte;
  } track_cmd_t;

  class track_run_checker;
    result_t     pending_runs[$];
    result_t     batch[$];
    logic [15:0] data_crc;
    logic [10:0] bytes_left;
    bit          field_open;
    bit          crc_flip;
    int          mismatches, runs_checked;
    int          starts, headers, data_bytes, ignored, fields_closed, fields_dropped;

    function new();
      data_crc = 16'hFFFF;
      bytes_left = '0;
      field_open = 0;
      crc_flip = 0;
    endfunction

    function logic [15:0] crc_shift(logic [15:0] acc, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = acc[15] ^ d[i];
        acc = {acc[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
      end
      return crc_shift_done(acc);
    endfunction

    function logic [15:0] crc_shift_done(logic [15:0] acc);
      return acc;
    endfunction

    function void add_run(logic [7:0] v, logic [6:0] len, logic m);
      result_t r;
      r.byte_value = v;
      r.run_length = len;
      r.id_mark = m;
      r.last = 1'b0;
      batch.insert(batch.size(), r);
    endfunction

    function void close_field();
      if (field_open) fields_dropped++;
      field_open = 0;
      bytes_left = '0;
    endfunction

    function void accept_item(track_cmd_t c);
      logic [15:0] id_crc;
      logic [15:0] out_crc;
      logic [7:0]  dmark;
      batch.delete();
      case (c.op)
        OP_START: begin
          starts++;
          close_field();
          add_run(B_GAP, 7'd80, 1'b0);
          add_run(B_ZERO, 7'd12, 1'b0);
          add_run(B_INDEX_SYNC, 7'd3, 1'b0);
          add_run(B_INDEX_MARK, 7'd1, 1'b0);
          add_run(B_GAP, 7'd50, 1'b0);
        end
        OP_HEADER: begin
          headers++;
          close_field();
          if (c.status != ST_NO_ID) begin
            id_crc = 16'hFFFF;
            id_crc = crc_shift(id_crc, B_SYNC_A1);
            id_crc = crc_shift(id_crc, B_SYNC_A1);
            id_crc = crc_shift(id_crc, B_SYNC_A1);
            id_crc = crc_shift(id_crc, B_ID_MARK);
            id_crc = crc_shift(id_crc, c.cyl);
            id_crc = crc_shift(id_crc, c.head);
            id_crc = crc_shift(id_crc, c.rec);
            id_crc = crc_shift(id_crc, c.size);
            if (c.status == ST_ID_CRC_ERR) id_crc = ~id_crc;
            add_run(B_ZERO, 7'd12, 1'b0);
            add_run(B_SYNC_A1, 7'd3, 1'b0);
            add_run(B_ID_MARK, 7'd1, 1'b1);
            add_run(c.cyl, 7'd1, 1'b0);
            add_run(c.head, 7'd1, 1'b0);
            add_run(c.rec, 7'd1, 1'b0);
            add_run(c.size, 7'd1, 1'b0);
            add_run(id_crc[15:8], 7'd1, 1'b0);
            add_run(id_crc[7:0], 7'd1, 1'b0);
            add_run(B_GAP, 7'd22, 1'b0);
            if (c.status != ST_NO_DATA) begin
              dmark = c.del ? B_DELETED_MARK : B_DATA_MARK;
              add_run(B_ZERO, 7'd12, 1'b0);
              add_run(B_SYNC_A1, 7'd3, 1'b0);
              add_run(dmark, 7'd1, 1'b0);
              data_crc = 16'hFFFF;
              data_crc = crc_shift(data_crc, B_SYNC_A1);
              data_crc = crc_shift(data_crc, B_SYNC_A1);
              data_crc = crc_shift(data_crc, B_SYNC_A1);
              data_crc = crc_shift(data_crc, dmark);
              bytes_left = 11'd128 << c.size[1:0];
              field_open = 1;
              crc_flip = (c.status == ST_DATA_CRC_ERR);
            end
          end
        end
        OP_DATA: begin
          if (!field_open) begin
            ignored++;
          end else begin
            data_bytes++;
            add_run(c.dbyte, 7'd1, 1'b0);
            data_crc = crc_shift(data_crc, c.dbyte);
            if (bytes_left != 0) bytes_left = bytes_left - 11'd1;
            if (bytes_left == 0) begin
              out_crc = crc_flip ? ~data_crc : data_crc;
              add_run(out_crc[15:8], 7'd1, 1'b0);
              add_run(out_crc[7:0], 7'd1, 1'b0);
              add_run(B_GAP, 7'd84, 1'b0);
              field_open = 0;
              fields_closed++;
            end
          end
        end
        default: ignored++;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending_runs.insert(pending_runs.size(), batch[i]);
    endfunction

    task report(string what, logic [7:0] want, logic [7:0] got);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch at run %0d: %s expected %0h got %0h", runs_checked, what, want, got);
    endtask

    task check_run(logic [7:0] v, logic [6:0] len, logic m, logic l);
      result_t want;
      runs_checked++;
      if (pending_runs.size() == 0) begin
        report("unexpected run, byte_value", 8'h00, v);
        return;
      end
      want = pending_runs.pop_front();
      if (v !== want.byte_value) report("byte_value", want.byte_value, v);
      if (len !== want.run_length) report("run_length", {1'b0, want.run_length}, {1'b0, len});
      if (m !== want.id_mark) report("id_mark", {7'd0, want.id_mark}, {7'd0, m});
      if (l !== want.last) report("last", {7'd0, want.last}, {7'd0, l});
    endtask
  endclass

  logic clk;
  logic rst;
  bit   hold_off_req;
  bit   src_steady;
  int   idle_cycles;
  int   live_items;

  track_run_checker sb;

  mtif_in_if  items_if ();
  mtif_out_if runs_if ();

  mfm_track_image_formatter dut (
    .clk   (clk),
    .rst   (rst),
    .items (items_if.sink),
    .runs  (runs_if.source)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic track_cmd_t rand_cmd(logic [1:0] op);
    track_cmd_t c;
    c = track_cmd_t'({$urandom, $urandom});
    c.op = op;
    return c;
  endfunction

  function automatic track_cmd_t make_header(logic [7:0] cyl, logic [7:0] head,
                                             logic [7:0] rec, logic [7:0] size,
                                             logic [7:0] status, logic del);
    track_cmd_t c;
    c = rand_cmd(OP_HEADER);
    c.cyl = cyl;
    c.head = head;
    c.rec = rec;
    c.size = size;
    c.status = status;
    c.del = del;
    return c;
  endfunction

  function automatic track_cmd_t make_data(logic [7:0] b);
    track_cmd_t c;
    c = rand_cmd(OP_DATA);
    c.dbyte = b;
    return c;
  endfunction

  function automatic logic [7:0] pick_status();
    case ($urandom_range(0, 9))
      0: return ST_ID_CRC_ERR;
      1: return ST_DATA_CRC_ERR;
      2: return ST_NO_ID;
      3: return ST_NO_DATA;
      default: return 8'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic push_item(track_cmd_t c);
    int gap;
    gap = 0;
    if (!src_steady && $urandom_range(0, 3) == 0) gap = idle_gap();
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_if.operation     <= c.op;
    items_if.cylinder      <= c.cyl;
    items_if.head_id       <= c.head;
    items_if.record_id     <= c.rec;
    items_if.size_code     <= c.size;
    items_if.sector_status <= c.status;
    items_if.deleted       <= c.del;
    items_if.data_byte     <= c.dbyte;
    items_if.valid         <= 1'b1;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    items_if.valid <= 1'b0;
    while (sb.pending_runs.size() != 0) @(negedge clk);
  endtask

  task automatic push_sector(int size_low, bit truncate);
    track_cmd_t h;
    int len, nbytes;
    h = rand_cmd(OP_HEADER);
    h.status = pick_status();
    h.size[1:0] = 2'(size_low);
    push_item(h);
    live_items++;
    if (h.status == ST_NO_ID || h.status == ST_NO_DATA) return;
    len = 128 << size_low;
    nbytes = truncate ? $urandom_range(0, 40) : len;
    repeat (nbytes) begin
      push_item(make_data(8'($urandom)));
      live_items++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (runs_if.valid && runs_if.ready)
        sb.check_run(runs_if.byte_value, runs_if.run_length, runs_if.id_mark, runs_if.last);
      if (items_if.valid && items_if.ready)
        sb.accept_item('{op: items_if.operation, cyl: items_if.cylinder,
                         head: items_if.head_id, rec: items_if.record_id,
                         size: items_if.size_code, status: items_if.sector_status,
                         del: items_if.deleted, dbyte: items_if.data_byte});
    end
  end

  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) || (runs_if.valid && runs_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d runs outstanding",
               idle_cycles, sb.pending_runs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // output side: random stalls, a long hold-off on request, quiet stretches
  initial begin
    int  hold;
    int  mode_left;
    bit  steady;
    hold = 0;
    mode_left = 0;
    steady = 0;
    runs_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (mode_left == 0) begin
        steady = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_off_req) begin
        hold_off_req = 0;
        hold = HOLD_OFF_CYCLES;
      end else if (hold == 0 && !steady && $urandom_range(0, 4) == 0) begin
        hold = idle_gap();
      end
      if (hold > 0) begin
        runs_if.ready <= 1'b0;
        hold--;
      end else begin
        runs_if.ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  initial begin
    track_cmd_t c;
    int sel;
    sb = new();
    idle_cycles = 0;
    live_items = 0;
    hold_off_req = 0;
    src_steady = 0;
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.operation = OP_START;
    items_if.cylinder = '0;
    items_if.head_id = '0;
    items_if.record_id = '0;
    items_if.size_code = '0;
    items_if.sector_status = '0;
    items_if.deleted = 1'b0;
    items_if.data_byte = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: ignored items, every operation, status cases, abandoned fields
    push_item(rand_cmd(2'd3));
    push_item(make_data(8'hFF));
    push_item(rand_cmd(OP_START));
    push_item(make_header(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    push_item(make_data(8'h00));
    push_item(make_data(8'hFF));
    push_item(rand_cmd(2'd3));
    push_item(make_data(8'h5A));
    push_item(make_header(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    push_item(make_data(8'hA5));
    push_item(rand_cmd(OP_START));
    push_item(make_data(8'h01));
    push_item(make_header(8'h12, 8'h01, 8'h07, 8'h02, ST_NO_ID, 1'b0));
    push_item(make_data(8'h80));
    push_item(make_header(8'h4F, 8'h00, 8'hF1, 8'h01, ST_NO_DATA, 1'b1));
    push_item(make_data(8'h7F));
    push_item(make_header(8'h28, 8'h01, 8'h09, 8'hFC, ST_ID_CRC_ERR, 1'b1));
    push_item(make_data(8'h33));
    push_item(make_header(8'h81, 8'h80, 8'h55, 8'h03, ST_DATA_CRC_ERR, 1'b0));
    push_item(make_data(8'hCC));
    push_item(make_header(8'h01, 8'hFE, 8'hAA, 8'h80, ST_NO_ID, 1'b0));
    push_item(make_data(8'h0F));

    // sender waits for the block to empty, then the receiver holds off
    drain();
    hold_off_req = 1;

    while (live_items < ITEM_BUDGET) begin
      src_steady = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 19);
      if (sel < 2) begin
        push_item(rand_cmd(OP_START));
        live_items++;
      end else if (sel < 4) begin
        c = rand_cmd(2'($urandom_range(0, 3)));
        if (c.op == OP_HEADER) c.status = pick_status();
        push_item(c);
        live_items++;
      end else if (sel == 4 || live_items > ITEM_BUDGET - 129) begin
        push_sector($urandom_range(0, 3), 1'b1);
      end else begin
        push_sector((live_items < ITEM_BUDGET - 257 && $urandom_range(0, 4) == 0) ? 1 : 0,
                    1'b0);
      end
      if ($urandom_range(0, 14) == 0) drain();
    end

    src_steady = 0;
    drain();
    repeat (20) @(negedge clk);

    $display("covered %0d starts, %0d headers, %0d data bytes, %0d ignored items, %0d runs",
             sb.starts, sb.headers, sb.data_bytes, sb.ignored, sb.runs_checked);
    $display("%0d data fields closed with CRC, %0d abandoned, %0d mismatches",
             sb.fields_closed, sb.fields_dropped, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_runs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
